// File: hw/rtl/wftc_pkg.sv
// Shared types and constants for the windowed failure trip counter.
package wftc_pkg;

    localparam int unsigned TIME_WIDTH_DEF = 32;
    localparam int unsigned OP_W           = 2;
    localparam int unsigned NOW_W          = 32;
    localparam int unsigned COUNT_W        = 16;
    localparam int unsigned THR_W          = 16;
    localparam int unsigned WIN_W          = 32;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned CFG_DATA_W     = 32;

    localparam logic [THR_W-1:0]   RESET_THRESHOLD = THR_W'(5);
    localparam logic [WIN_W-1:0]   RESET_WINDOW    = WIN_W'(1000);
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    typedef enum logic [OP_W-1:0] {
        OP_FAILURE = 2'd0,
        OP_SUCCESS = 2'd1,
        OP_CONSUME = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIP_THRESHOLD = 1'd0,
        CFG_WINDOW_TICKS   = 1'd1
    } t_cfg_index;

    typedef struct packed {
        logic [THR_W-1:0] trip_threshold;
        logic [WIN_W-1:0] window_ticks;
    } t_cfg;

    typedef struct packed {
        logic               trip_flag;
        logic [COUNT_W-1:0] failure_count;
        logic               tripped;
    } t_result;

endpackage

// File: hw/rtl/wftc_event_if.sv
// Event channel: opcode and timestamp with valid/ready handshake.
interface wftc_event_if;
    logic                        valid;
    logic                        ready;
    logic [wftc_pkg::OP_W-1:0]   opcode;
    logic [wftc_pkg::NOW_W-1:0]  now_ticks;

    modport source (output valid, output opcode, output now_ticks, input ready);
    modport sink   (input valid, input opcode, input now_ticks, output ready);
endinterface

// File: hw/rtl/wftc_result_if.sv
// Result channel: trip flag, failure count and sticky trip state.
interface wftc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          trip_flag_out;
    logic [wftc_pkg::COUNT_W-1:0]  failure_count_out;
    logic                          tripped_out;

    modport source (output valid, output trip_flag_out, output failure_count_out,
                    output tripped_out, input ready);
    modport sink   (input valid, input trip_flag_out, input failure_count_out,
                    input tripped_out, output ready);
endinterface

// File: hw/rtl/wftc_core.sv
// Tracker state and per-event update logic.
module wftc_core #(
    parameter int unsigned TIME_WIDTH = wftc_pkg::TIME_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  wftc_pkg::t_opcode           i_op,
    input  logic [wftc_pkg::NOW_W-1:0]  i_now,
    input  wftc_pkg::t_cfg              i_cfg,
    output wftc_pkg::t_result           o_res
);

    localparam int unsigned CW = (TIME_WIDTH > wftc_pkg::WIN_W) ? TIME_WIDTH : wftc_pkg::WIN_W;

    logic [wftc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [TIME_WIDTH-1:0]        r_win_start, n_win_start;
    logic [TIME_WIDTH-1:0]        r_last_fail, n_last_fail;
    logic                         r_tripped, n_tripped;

    logic [CW-1:0]                now_ext;
    logic [TIME_WIDTH-1:0]        now_t;
    logic [TIME_WIDTH-1:0]        diff_ws;
    logic [TIME_WIDTH-1:0]        diff_lf;
    logic                         beyond_ws;
    logic                         beyond_lf;
    logic                         fresh;
    logic [wftc_pkg::COUNT_W-1:0] cnt_base;
    logic [wftc_pkg::COUNT_W-1:0] cnt_inc;
    logic                         flag;

    assign now_ext   = CW'(i_now);
    assign now_t     = now_ext[TIME_WIDTH-1:0];
    assign diff_ws   = now_t - r_win_start;
    assign diff_lf   = now_t - r_last_fail;
    assign beyond_ws = CW'(diff_ws) > CW'(i_cfg.window_ticks);
    assign beyond_lf = CW'(diff_lf) > CW'(i_cfg.window_ticks);
    assign fresh     = (r_count == '0) || beyond_ws;
    assign cnt_base  = fresh ? '0 : r_count;
    assign cnt_inc   = (cnt_base == wftc_pkg::COUNT_MAX) ? cnt_base
                                                          : cnt_base + 1'b1;

    always_comb begin
        n_count     = r_count;
        n_win_start = r_win_start;
        n_last_fail = r_last_fail;
        n_tripped   = r_tripped;
        flag        = 1'b0;
        case (i_op)
            wftc_pkg::OP_FAILURE: begin
                n_win_start = fresh ? now_t : r_win_start;
                n_last_fail = now_t;
                n_count     = cnt_inc;
                if (cnt_inc >= i_cfg.trip_threshold) begin
                    n_tripped = 1'b1;
                    flag      = 1'b1;
                end
            end
            wftc_pkg::OP_SUCCESS: begin
                if (r_count != '0 && beyond_lf) begin
                    n_count     = '0;
                    n_win_start = '0;
                end
            end
            wftc_pkg::OP_CONSUME: begin
                if (r_tripped) begin
                    n_tripped   = 1'b0;
                    n_count     = '0;
                    n_win_start = '0;
                    flag        = 1'b1;
                end
            end
            wftc_pkg::OP_CLEAR: begin
                n_count     = '0;
                n_win_start = '0;
                n_last_fail = '0;
                n_tripped   = 1'b0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_res.trip_flag     = flag;
    assign o_res.failure_count = n_count;
    assign o_res.tripped       = n_tripped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_win_start <= '0;
            r_last_fail <= '0;
            r_tripped   <= 1'b0;
        end else if (i_adv) begin
            r_count     <= n_count;
            r_win_start <= n_win_start;
            r_last_fail <= n_last_fail;
            r_tripped   <= n_tripped;
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_op == wftc_pkg::OP_CLEAR |=> r_count == '0 && !r_tripped)
        else $error("clear left state behind");

    a_failure_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_op == wftc_pkg::OP_FAILURE |=> r_count != '0)
        else $error("failure did not raise count");

    a_consume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_op == wftc_pkg::OP_CONSUME && r_tripped
        |=> !r_tripped && r_count == '0)
        else $error("consume did not clear trip");

    a_trip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tripped && !i_adv |=> r_tripped)
        else $error("trip flag dropped without an event");

endmodule

// File: hw/rtl/windowed_failure_trip_counter.sv
// Top level: event register, tracker core, result register and config registers.
//
//  channel   dir  transaction payload
//  i_event   in   opcode, now_ticks
//  o_result  out  trip_flag_out, failure_count_out, tripped_out
//  i_cfg_*   in   write enable, register index, data
//
// One event per cycle sustained while o_result is ready, as set by the core's
// state update; a result passes the input register, then the output register.
// Reset is synchronous; state clears to zero, threshold 5, window 1000 ticks.
// A stalled result holds in the output register while one more event waits in
// the input register.
module windowed_failure_trip_counter #(
    parameter int unsigned TIME_WIDTH = wftc_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wftc_event_if.sink                        i_event,
    wftc_result_if.source                     o_result,
    input  logic                              i_cfg_we,
    input  logic [wftc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wftc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                        r_in_valid;
    wftc_pkg::t_opcode           r_in_op;
    logic [wftc_pkg::NOW_W-1:0]  r_in_now;
    logic                        r_out_valid;
    wftc_pkg::t_result           r_out;
    wftc_pkg::t_cfg              r_cfg;
    wftc_pkg::t_result           core_res;
    logic                        adv;
    logic                        in_ready;

    assign adv      = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || adv;
    assign i_event.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_event.valid) begin
            r_in_op  <= wftc_pkg::t_opcode'(i_event.opcode);
            r_in_now <= i_event.now_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trip_threshold <= wftc_pkg::RESET_THRESHOLD;
            r_cfg.window_ticks   <= wftc_pkg::RESET_WINDOW;
        end else if (i_cfg_we) begin
            case (wftc_pkg::t_cfg_index'(i_cfg_idx))
                wftc_pkg::CFG_TRIP_THRESHOLD: begin
                    r_cfg.trip_threshold <= i_cfg_data[wftc_pkg::THR_W-1:0];
                end
                wftc_pkg::CFG_WINDOW_TICKS: begin
                    r_cfg.window_ticks <= i_cfg_data[wftc_pkg::WIN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    wftc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_op    (r_in_op),
        .i_now   (r_in_now),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.trip_flag_out     = r_out.trip_flag;
    assign o_result.failure_count_out = r_out.failure_count;
    assign o_result.tripped_out       = r_out.tripped;

endmodule
